// File: design/mcot_pkg.sv
package mcot_pkg;

    // Command codes carried on the kind field. Codes 6 and 7 behave as a query.
    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_ARM_SAMPLES = 3'd1;
    localparam logic [2:0] KIND_ARM_MS      = 3'd2;
    localparam logic [2:0] KIND_COPY        = 3'd3;
    localparam logic [2:0] KIND_CLEAR       = 3'd4;
    localparam logic [2:0] KIND_QUERY       = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICKS_PER_MS  = 2'd0;
    localparam logic [1:0] CFG_REARM_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_REARM_CHANNEL = 2'd2;
    localparam logic [1:0] CFG_REARM_MS      = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  RST_TICKS_PER_MS  = 8'd44;
    localparam logic        RST_REARM_ENABLE  = 1'b1;
    localparam logic [4:0]  RST_REARM_CHANNEL = 5'd14;
    localparam logic [15:0] RST_REARM_MS      = 16'd15;

    // Largest positive wrapping distance; also the idle value of the next-event cache.
    localparam logic [31:0] FAR_AWAY = 32'h7FFF_FFFF;

    // At most this many firings are reported per tick.
    localparam logic [5:0] RESULT_LIMIT = 6'd32;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_MUL  = 7'b000_0010,
        S_ARM  = 7'b000_0100,
        S_CPY  = 7'b000_1000,
        S_WALK = 7'b001_0000,
        S_FIN  = 7'b010_0000,
        S_DONE = 7'b100_0000
    } t_state;

endpackage

// File: design/multi_channel_oneshot_timer.sv
// Sequence: an arm on a valid channel passes through the states MUL, ARM and DONE, and a copy
// between valid channels through MUL, CPY and DONE; every other command that does not walk the
// bank goes through MUL and DONE. A valid clear, or a tick whose cached next event has passed,
// walks the bank in WALK and gives its final result from FIN. One transaction at a time, and busy
// falls as the final result shows; a walk reads one deadline per cycle from the deadline memory.
// Reset (synchronous, active low) clears the active flags, parks the next-event cache far away
// and restores the configuration defaults; results are single-cycle strobes, no stalls.
module multi_channel_oneshot_timer
    import mcot_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_kind,
    input  logic [31:0]           i_now,
    input  logic [4:0]            i_channel,
    input  logic [4:0]            i_source_channel,
    input  logic [23:0]           i_delay,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output logic                  o_fired,
    output logic [4:0]            o_fired_channel,
    output logic                  o_is_set,
    output logic                  o_last
);

    // Width of a channel index, and the channel count as seen by the range checks.
    localparam int          IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0]  NCH      = 7'(CHANNELS);
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state          r_state, n_state;

    // Configuration.
    logic [7:0]      r_ticks_per_ms;
    logic            r_rearm_enable;
    logic [4:0]      r_rearm_channel;
    logic [15:0]     r_rearm_ms;

    // The transaction being worked on.
    logic [2:0]      r_kind;
    logic [31:0]     r_now;
    logic [4:0]      r_channel;
    logic [4:0]      r_source;
    logic [23:0]     r_delay;

    // Timer state. Deadlines live in the memory; the active flags are flip-flops so
    // that reset clears them at once.
    logic [CHANNELS-1:0] r_active, n_active;
    logic [31:0]     r_next_event, n_next_event;

    // Working registers of the sequencer.
    logic [31:0]     r_samples, n_samples;
    logic [IW-1:0]   r_idx, n_idx;
    logic [31:0]     r_best, n_best;
    logic [5:0]      r_count, n_count;

    // One firing is held back so that the final one of a walk can carry last.
    logic            r_pend_vld, n_pend_vld;
    logic [4:0]      r_pend_ch, n_pend_ch;
    logic            r_pend_set, n_pend_set;

    // Registered result port.
    logic            r_strobe, n_strobe;
    logic            r_fired, n_fired;
    logic [4:0]      r_fch, n_fch;
    logic            r_set, n_set;
    logic            r_last, n_last;

    // ------------------------------------------------------------------
    // Shared arithmetic
    // ------------------------------------------------------------------
    logic [31:0]     ram_rdata;
    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata;

    logic            accept;
    logic            is_tick;
    logic            ch_ok, src_ok;
    logic [IW-1:0]   ch_idx, src_idx;
    logic [23:0]     mul_a;
    logic [31:0]     product;
    logic [31:0]     ms_samples;
    logic [31:0]     sub_a, diff;
    logic [31:0]     add_b, sum;
    logic            act_k, fire_k, rearm_k, keep_k;
    logic [31:0]     cand_k;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign is_tick = (r_kind == KIND_TICK);

    // A channel number at or above CHANNELS addresses nothing.
    assign ch_ok   = ({2'b00, r_channel} < NCH);
    assign src_ok  = ({2'b00, r_source} < NCH);
    assign ch_idx  = IW'(r_channel);
    assign src_idx = IW'(r_source);

    // Milliseconds to samples: one 24 x 8 multiplier serves both the millisecond arm
    // and the re-arm delay, and its product saturates at the largest positive distance.
    assign mul_a      = is_tick ? {8'd0, r_rearm_ms} : r_delay;
    assign product    = {8'd0, mul_a} * {24'd0, r_ticks_per_ms};
    assign ms_samples = product[31] ? FAR_AWAY : product;

    // One subtractor gives every wrapping distance to "now": the cache's during
    // dispatch and arming, and each deadline's during the walk.
    assign sub_a = (r_state == S_WALK) ? ram_rdata : r_next_event;
    assign diff  = sub_a - r_now;

    // One adder builds every new absolute time from "now".
    assign add_b = (r_state == S_FIN) ? r_best : r_samples;
    assign sum   = r_now + add_b;

    // Per-channel decisions of the walk, for the channel whose deadline is on the
    // memory output this cycle.
    assign act_k   = r_active[r_idx];
    assign fire_k  = is_tick && act_k && diff[31];
    assign rearm_k = fire_k && r_rearm_enable && ({2'b00, r_rearm_channel} == 7'(r_idx));
    assign keep_k  = fire_k ? rearm_k : act_k;
    // A re-armed channel lies exactly its re-arm delay ahead of "now".
    assign cand_k  = rearm_k ? r_samples : diff;

    mcot_ram #(
        .WIDTH (32),
        .DEPTH (CHANNELS)
    ) u_deadline (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_next_event = r_next_event;
        n_samples    = r_samples;
        n_idx        = r_idx;
        n_best       = r_best;
        n_count      = r_count;
        n_pend_vld   = r_pend_vld;
        n_pend_ch    = r_pend_ch;
        n_pend_set   = r_pend_set;
        n_strobe     = 1'b0;
        n_fired      = 1'b0;
        n_fch        = 5'd0;
        n_set        = 1'b0;
        n_last       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = ch_idx;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = src_idx;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end

            // The product is registered here, and the command is dispatched. Walks
            // start their first memory read in this cycle.
            S_MUL: begin
                n_samples  = (r_kind == KIND_ARM_SAMPLES) ? {8'd0, r_delay} : ms_samples;
                n_idx      = '0;
                n_best     = FAR_AWAY;
                n_count    = 6'd0;
                n_pend_vld = 1'b0;
                if (is_tick) begin
                    // Walk only when the cached next event lies strictly in the past.
                    if (diff[31]) begin
                        n_state   = S_WALK;
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!ch_ok) begin
                    n_state = S_DONE;
                end else begin
                    unique case (r_kind) inside
                        KIND_ARM_SAMPLES, KIND_ARM_MS: begin
                            n_state = S_ARM;
                        end
                        KIND_COPY: begin
                            if (src_ok) begin
                                n_state = S_CPY;
                                ram_re  = 1'b1;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        KIND_CLEAR: begin
                            n_active[ch_idx] = 1'b0;
                            n_state          = S_WALK;
                            ram_re           = 1'b1;
                            ram_raddr        = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ARM: begin
                ram_we           = 1'b1;
                ram_waddr        = ch_idx;
                ram_wdata        = sum;
                n_active[ch_idx] = 1'b1;
                // Pull the cache in if this deadline comes sooner than the cached one.
                if ($signed(r_samples) < $signed(diff)) begin
                    n_next_event = sum;
                end
                n_state = S_DONE;
            end

            S_CPY: begin
                ram_we           = 1'b1;
                ram_waddr        = ch_idx;
                ram_wdata        = ram_rdata;
                n_active[ch_idx] = 1'b1;
                n_state          = S_DONE;
            end

            S_WALK: begin
                if (fire_k) begin
                    n_active[r_idx] = rearm_k;
                    if (rearm_k) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx;
                        ram_wdata = sum;
                    end
                    if (r_count < RESULT_LIMIT) begin
                        // Release the previous firing, which is now known not to be final.
                        if (r_pend_vld) begin
                            n_strobe = 1'b1;
                            n_fired  = 1'b1;
                            n_fch    = r_pend_ch;
                            n_set    = r_pend_set;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_ch  = 5'(r_idx);
                        n_pend_set = rearm_k;
                        n_count    = r_count + 6'd1;
                    end
                end
                // Running minimum of the distances of the channels that stay active.
                if (keep_k && ($signed(cand_k) < $signed(r_best))) begin
                    n_best = cand_k;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx     = IW'(r_idx + 1'b1);
                    ram_re    = 1'b1;
                    ram_raddr = IW'(r_idx + 1'b1);
                end
            end

            // Close the walk: refresh the cache and report the held firing as final.
            // A walk that fired nothing, and every clear, ends in a plain result.
            S_FIN: begin
                n_next_event = sum;
                n_strobe     = 1'b1;
                n_fired      = r_pend_vld;
                n_fch        = r_pend_vld ? r_pend_ch : 5'd0;
                n_set        = r_pend_vld && r_pend_set;
                n_last       = 1'b1;
                n_state      = S_IDLE;
            end

            S_DONE: begin
                n_strobe = 1'b1;
                n_set    = !is_tick && ch_ok && r_active[ch_idx];
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_active        <= '0;
            r_next_event    <= FAR_AWAY;
            r_pend_vld      <= 1'b0;
            r_count         <= 6'd0;
            r_strobe        <= 1'b0;
            r_ticks_per_ms  <= RST_TICKS_PER_MS;
            r_rearm_enable  <= RST_REARM_ENABLE;
            r_rearm_channel <= RST_REARM_CHANNEL;
            r_rearm_ms      <= RST_REARM_MS;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_next_event <= n_next_event;
            r_pend_vld   <= n_pend_vld;
            r_count      <= n_count;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TICKS_PER_MS:  r_ticks_per_ms  <= i_cfg_wdata[7:0];
                    CFG_REARM_ENABLE:  r_rearm_enable  <= i_cfg_wdata[0];
                    CFG_REARM_CHANNEL: r_rearm_channel <= i_cfg_wdata[4:0];
                    CFG_REARM_MS:      r_rearm_ms      <= i_cfg_wdata[15:0];
                    default:           r_rearm_ms      <= r_rearm_ms;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_kind;
            r_now     <= i_now;
            r_channel <= i_channel;
            r_source  <= i_source_channel;
            r_delay   <= i_delay;
        end
        r_samples  <= n_samples;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_pend_ch  <= n_pend_ch;
        r_pend_set <= n_pend_set;
        r_fired    <= n_fired;
        r_fch      <= n_fch;
        r_set      <= n_set;
        r_last     <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_fired         = r_fired;
    assign o_fired_channel = r_fch;
    assign o_is_set        = r_set;
    assign o_last          = r_last;

endmodule

// File: design/mcot_ram.sv
module mcot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/mcot_checker.sv
module mcot_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_fired,
    input logic [4:0] o_fired_channel,
    input logic       o_last
);

    // An accepted transaction keeps the block busy and never answers in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted transaction did not hold the block busy");

    // The final result of a transaction frees the block in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("block still busy on the final result");

    // Only firings are reported ahead of the final result, while the walk is running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (busy && o_fired))
        else $error("non-final result outside a walk or without a firing");

    // A result that reports no expiry names no channel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_fired) |-> (o_fired_channel == 5'd0))
        else $error("channel number given without a firing");

endmodule

bind multi_channel_oneshot_timer mcot_checker u_mcot_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_fired         (o_fired),
    .o_fired_channel (o_fired_channel),
    .o_last          (o_last)
);

// File: test/multi_channel_oneshot_timer_tb.sv
module multi_channel_oneshot_timer_tb;
    import mcot_pkg::*;

    localparam int CHANNELS = 32;

    // Kind codes outside the defined set; the block treats both as a query.
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // The longest legitimate stretch without any transaction is the pause between
    // phases plus one full walk of the bank.
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic       fired;
        logic [4:0] fired_channel;
        logic       is_set;
        logic       last;
    } t_timer_report;

    // Shadow copy of the timer bank: deadlines, active flags, the next-event
    // cache and the four configuration registers, plus the reports still owed.
    class t_timer_bank_shadow;
        logic [31:0]   deadline [CHANNELS];
        bit            active   [CHANNELS];
        bit            written  [CHANNELS];
        logic [31:0]   next_due;
        logic [7:0]    ticks_per_ms;
        logic          rearm_on;
        logic [4:0]    rearm_ch;
        logic [15:0]   rearm_ms;
        t_timer_report pending_reports [$];
        int unsigned   mismatches;

        function new();
            foreach (deadline[i]) begin
                deadline[i] = '0;
                active[i]   = 1'b0;
                written[i]  = 1'b0;
            end
            next_due     = FAR_AWAY;
            ticks_per_ms = RST_TICKS_PER_MS;
            rearm_on     = RST_REARM_ENABLE;
            rearm_ch     = RST_REARM_CHANNEL;
            rearm_ms     = RST_REARM_MS;
            mismatches   = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_TICKS_PER_MS:  ticks_per_ms = value[7:0];
                CFG_REARM_ENABLE:  rearm_on     = value[0];
                CFG_REARM_CHANNEL: rearm_ch     = value[4:0];
                CFG_REARM_MS:      rearm_ms     = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] ms_to_samples(logic [31:0] ms);
            logic [63:0] product;
            product = 64'(ms) * 64'(ticks_per_ms);
            return (product > 64'(FAR_AWAY)) ? FAR_AWAY : product[31:0];
        endfunction

        function void arm(int unsigned idx, logic [31:0] now, logic [31:0] samples);
            deadline[idx] = now + samples;
            active[idx]   = 1'b1;
            written[idx]  = 1'b1;
            if ($signed(samples) < $signed(next_due - now))
                next_due = deadline[idx];
        endfunction

        // Earliest deadline among the active channels, seen from now.
        function void recompute(logic [31:0] now);
            logic signed [31:0] best;
            logic signed [31:0] gap;
            best = FAR_AWAY;
            for (int i = 0; i < CHANNELS; i++) begin
                if (active[i]) begin
                    gap = deadline[i] - now;
                    if (gap < best)
                        best = gap;
                end
            end
            next_due = now + best;
        endfunction

        function void apply_command(logic [2:0] kind, logic [31:0] now, logic [4:0] ch,
                                    logic [4:0] src, logic [23:0] delay);
            int unsigned fired_count;
            bit          ch_ok;
            fired_count = 0;
            ch_ok = (ch < CHANNELS);
            if (kind == KIND_TICK) begin
                if ($signed(next_due - now) < 0) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (active[i] && $signed(deadline[i] - now) < 0) begin
                            active[i] = 1'b0;
                            if (rearm_on && i == rearm_ch)
                                arm(i, now, ms_to_samples(32'(rearm_ms)));
                            if (fired_count < RESULT_LIMIT) begin
                                pending_reports.push_back(
                                    t_timer_report'{1'b1, 5'(i), active[i], 1'b0});
                                fired_count++;
                            end
                        end
                    end
                    recompute(now);
                end
                if (fired_count == 0)
                    pending_reports.push_back(t_timer_report'{1'b0, 5'd0, 1'b0, 1'b1});
                else
                    pending_reports[pending_reports.size() - 1].last = 1'b1;
                return;
            end
            if (ch_ok) begin
                case (kind)
                    KIND_ARM_SAMPLES: arm(ch, now, 32'(delay));
                    KIND_ARM_MS:      arm(ch, now, ms_to_samples(32'(delay)));
                    KIND_COPY: begin
                        if (src < CHANNELS) begin
                            deadline[ch] = deadline[src];
                            active[ch]   = 1'b1;
                            written[ch]  = 1'b1;
                        end
                    end
                    KIND_CLEAR: begin
                        active[ch] = 1'b0;
                        recompute(now);
                    end
                    default: ;
                endcase
            end
            pending_reports.push_back(
                t_timer_report'{1'b0, 5'd0, ch_ok && active[ch], 1'b1});
        endfunction

        task flag_mismatch(string what);
            $display("ERROR at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_report(t_timer_report got);
            t_timer_report want;
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("unexpected result fired=%0d channel=%0d",
                                        got.fired, got.fired_channel));
                return;
            end
            want = pending_reports.pop_front();
            if (got.fired !== want.fired)
                flag_mismatch($sformatf("fired %0d, wanted %0d", got.fired, want.fired));
            if (got.fired_channel !== want.fired_channel)
                flag_mismatch($sformatf("fired_channel %0d, wanted %0d",
                                        got.fired_channel, want.fired_channel));
            if (got.is_set !== want.is_set)
                flag_mismatch($sformatf("is_set %0d, wanted %0d (channel %0d)",
                                        got.is_set, want.is_set, want.fired_channel));
            if (got.last !== want.last)
                flag_mismatch($sformatf("last %0d, wanted %0d", got.last, want.last));
        endtask
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic [2:0]            i_kind           = KIND_QUERY;
    logic [31:0]           i_now            = '0;
    logic [4:0]            i_channel        = '0;
    logic [4:0]            i_source_channel = '0;
    logic [23:0]           i_delay          = '0;
    logic                  i_cfg_we         = 1'b0;
    logic [1:0]            i_cfg_index      = CFG_TICKS_PER_MS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata      = '0;
    logic                  o_strobe;
    logic                  o_fired;
    logic [4:0]            o_fired_channel;
    logic                  o_is_set;
    logic                  o_last;

    t_timer_bank_shadow shadow;

    // Running sample clock used by the random part, so that arming and ticking
    // follow one another in time and channels really expire.
    logic [31:0] sample_clock;
    int unsigned quiet_cycles = 0;

    multi_channel_oneshot_timer #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_now            (i_now),
        .i_channel        (i_channel),
        .i_source_channel (i_source_channel),
        .i_delay          (i_delay),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_fired          (o_fired),
        .o_fired_channel  (o_fired_channel),
        .o_is_set         (o_is_set),
        .o_last           (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Every result strobe is checked against the oldest outstanding report.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            shadow.check_report(t_timer_report'{o_fired, o_fired_channel, o_is_set, o_last});
    end

    // The watchdog ends the run if no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge. The command is held until a rising edge sees busy
    // low, which is the moment the transaction is taken; start is left high so
    // that the caller can follow on directly or lower it.
    task automatic issue_command(input logic [2:0] kind, input logic [31:0] now,
                                 input logic [4:0] ch, input logic [4:0] src,
                                 input logic [23:0] delay);
        i_kind           = kind;
        i_now            = now;
        i_channel        = ch;
        i_source_channel = src;
        i_delay          = delay;
        start            = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        shadow.apply_command(kind, now, ch, src, delay);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(posedge i_clk);
        shadow.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Let every owed report arrive, then give the block time to finish any walk.
    task automatic settle();
        start = 1'b0;
        while (shadow.pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (CHANNELS + 4) @(negedge i_clk);
    endtask

    task automatic random_command();
        logic [2:0]  kind;
        logic [4:0]  ch;
        logic [4:0]  src;
        logic [23:0] delay;
        int unsigned pick;
        bit          found;
        pick = $urandom_range(0, 99);
        // Mostly modest steps forward; now and then a large jump to anywhere,
        // which leaves deadlines far in the past or the future.
        if (pick >= 15 && pick < 85)
            sample_clock += $urandom_range(1, 1500);
        else if (pick >= 85 && pick < 97)
            sample_clock += $urandom_range(1, 1 << 20);
        else if (pick >= 97)
            sample_clock = $urandom();

        pick = $urandom_range(0, 99);
        if (pick < 35)
            kind = KIND_TICK;
        else if (pick < 55)
            kind = KIND_ARM_SAMPLES;
        else if (pick < 70)
            kind = KIND_ARM_MS;
        else if (pick < 80)
            kind = KIND_COPY;
        else if (pick < 90)
            kind = KIND_CLEAR;
        else if (pick < 97)
            kind = KIND_QUERY;
        else
            kind = pick[0] ? KIND_SPARE_7 : KIND_SPARE_6;

        // Crowding onto a few channels makes multi-channel firings common.
        ch    = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 7))
                                             : 5'($urandom_range(0, 31));
        src   = 5'($urandom());
        delay = 24'($urandom());
        pick  = $urandom_range(0, 99);
        if (kind == KIND_ARM_SAMPLES && pick < 85)
            delay = 24'($urandom_range(0, 3000));
        if (kind == KIND_ARM_MS && pick < 85)
            delay = 24'($urandom_range(0, 12));

        // A copy may only read a deadline that has been written at some point.
        if (kind == KIND_COPY) begin
            found = 1'b0;
            for (int k = 0; k < CHANNELS && !found; k++) begin
                if (shadow.written[5'(src + k)]) begin
                    src   = 5'(src + k);
                    found = 1'b1;
                end
            end
            if (!found)
                kind = KIND_QUERY;
        end
        issue_command(kind, sample_clock, ch, src, delay);
    endtask

    task automatic run_random(input int count, input bit with_gaps);
        for (int n = 0; n < count; n++) begin
            if (with_gaps && $urandom_range(0, 99) < 30) begin
                start = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            random_command();
        end
    endtask

    initial begin
        shadow = new();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset configuration: ticks at 44 per ms, channel 14
        // re-arming itself after 15 ms.
        issue_command(KIND_QUERY,       32'd0,   5'd0,  5'd0,  24'd0);
        issue_command(KIND_TICK,        32'd0,   5'd0,  5'd0,  24'd0);
        issue_command(KIND_ARM_SAMPLES, 32'd100, 5'd0,  5'd0,  24'd0);
        issue_command(KIND_ARM_SAMPLES, 32'd100, 5'd31, 5'd0,  24'hFF_FFFF);
        issue_command(KIND_ARM_MS,      32'd100, 5'd14, 5'd0,  24'd1);
        issue_command(KIND_ARM_MS,      32'd100, 5'd5,  5'd0,  24'hFF_FFFF);
        issue_command(KIND_COPY,        32'd100, 5'd7,  5'd0,  24'd0);
        issue_command(KIND_COPY,        32'd120, 5'd8,  5'd31, 24'd0);
        issue_command(KIND_QUERY,       32'd120, 5'd31, 5'd0,  24'd0);
        issue_command(KIND_SPARE_6,     32'd120, 5'd0,  5'd0,  24'd0);
        issue_command(KIND_SPARE_7,     32'd120, 5'd9,  5'd0,  24'd0);
        // A deadline equal to now has not yet passed, so this tick stays quiet.
        issue_command(KIND_TICK,        32'd100, 5'd0,  5'd0,  24'd0);
        // Channels 0, 7 and 14 expire together; 14 comes back armed.
        issue_command(KIND_TICK,        32'd200, 5'd0,  5'd0,  24'd0);
        issue_command(KIND_CLEAR,       32'd300, 5'd5,  5'd0,  24'd0);
        issue_command(KIND_CLEAR,       32'd300, 5'd3,  5'd0,  24'd0);
        // A deadline that lies across the wrap of the sample clock.
        issue_command(KIND_ARM_SAMPLES, 32'hFFFF_FFF0, 5'd1, 5'd0, 24'h20);
        issue_command(KIND_TICK,        32'hFFFF_FFFF, 5'd0, 5'd0, 24'd0);
        issue_command(KIND_TICK,        32'h0000_0020, 5'd0, 5'd0, 24'd0);
        // Re-arming channel 3 later leaves the cache early: the next tick walks
        // the bank, finds nothing expired and refreshes the cache.
        issue_command(KIND_CLEAR,       32'd1000, 5'd14, 5'd0, 24'd0);
        issue_command(KIND_ARM_SAMPLES, 32'd1000, 5'd3,  5'd0, 24'd10);
        issue_command(KIND_ARM_SAMPLES, 32'd1000, 5'd3,  5'd0, 24'd5000);
        issue_command(KIND_TICK,        32'd2000, 5'd0,  5'd0, 24'd0);
        issue_command(KIND_COPY,        32'd2000, 5'd0,  5'd3, 24'd0);
        issue_command(KIND_TICK,        32'd7000, 5'd0,  5'd0, 24'd0);
        issue_command(KIND_QUERY,       32'd7000, 5'd3,  5'd0, 24'd0);
        settle();

        // Slowest millisecond, highest channel re-arming with no delay at all.
        write_register(CFG_TICKS_PER_MS,  16'd1);
        write_register(CFG_REARM_ENABLE,  16'd1);
        write_register(CFG_REARM_CHANNEL, 16'd31);
        write_register(CFG_REARM_MS,      16'd0);
        sample_clock = 32'hFFFF_C000;
        run_random(52, 1'b1);
        settle();

        // Fastest millisecond, re-arming switched off.
        write_register(CFG_TICKS_PER_MS,  16'd255);
        write_register(CFG_REARM_ENABLE,  16'd0);
        write_register(CFG_REARM_CHANNEL, 16'd0);
        write_register(CFG_REARM_MS,      16'hFFFF);
        sample_clock = $urandom();
        run_random(52, 1'b1);
        settle();

        // Final stretch: back-to-back transactions with no gaps.
        write_register(CFG_TICKS_PER_MS,  16'd200);
        write_register(CFG_REARM_ENABLE,  16'd1);
        write_register(CFG_REARM_CHANNEL, 16'd2);
        write_register(CFG_REARM_MS,      16'd3);
        run_random(52, 1'b0);
        settle();

        if (shadow.mismatches == 0 && shadow.pending_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
